// File: rtl/core/tts_pkg.sv
// shared constants for the tiled texture address generator
`default_nettype none

package tts_pkg;

	// configuration register layout
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_TEX_FORMAT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ORDER = 2'd3;

	// texture formats
	localparam int unsigned FMT_W = 2;
	localparam logic [FMT_W-1:0] FMT_RGBA8 = 2'd0;
	localparam logic [FMT_W-1:0] FMT_C8    = 2'd1;
	localparam logic [FMT_W-1:0] FMT_C4    = 2'd2;

	// field widths
	localparam int unsigned COORD_W  = 10;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned OFFSET_W = 22;
	localparam int unsigned PAIR_W   = 16;
	localparam int unsigned DIM_W    = 11;

	localparam int unsigned MAX_DIM_DEF = 1024;
	localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

	// stream word widths: payload padded to whole bytes
	localparam int unsigned S_PAYLOAD_W = 2 * COORD_W + VALUE_W;
	localparam int unsigned S_TDATA_W   = ((S_PAYLOAD_W + 7) / 8) * 8;
	localparam int unsigned M_PAYLOAD_W = OFFSET_W + 2 * PAIR_W;
	localparam int unsigned M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;

	// tile grid and in-tile offset widths
	localparam int unsigned TILE_POS_W = 8;
	localparam int unsigned TILE_CNT_W = 9;
	localparam int unsigned INNER_W    = 5;
	localparam int unsigned TILE_IDX_W = 17;

endpackage : tts_pkg

`default_nettype wire

// File: rtl/core/texture_tile_swizzle_address.sv
// tiled texture address generator: texel coordinates to swizzled byte offset
// throughput: one word per cycle while the output is not stalled;
// three registered stages (tile grid and drop check, tile index
// multiply-add, final offset and byte pairs)
// a stall at the output backs up through the stages; empty stages still fill
// reset empties the stages and returns the configuration registers to defaults
`default_nettype none

module texture_tile_swizzle_address #(
	parameter int unsigned MAX_DIM = tts_pkg::MAX_DIM_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [tts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tts_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// texel_x[9:0], texel_y[19:10], texel_value[51:20], zero pad[55:52]
	input  wire logic [tts_pkg::S_TDATA_W-1:0] s_tdata,
	// output stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// dest_offset[21:0], first_pair[37:22], second_pair[53:38], zero pad[55:54]
	output logic [tts_pkg::M_TDATA_W-1:0]      m_tdata,
	// dropped[0]
	output logic                               m_tuser
);

	import tts_pkg::*;

	localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIM);

	// configuration registers
	logic [FMT_W-1:0] fmt_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_RGBA8;
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
			order_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEX_FORMAT:    fmt_q    <= cfg_wdata[FMT_W-1:0];
				REG_TEX_WIDTH:     width_q  <= cfg_wdata;
				REG_TEX_HEIGHT:    height_q <= cfg_wdata;
				REG_CHANNEL_ORDER: order_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// stage enables
	logic valid_s1, valid_s2, valid_s3;
	logic en1, en2, en3;

	assign en3      = !valid_s3 || m_tready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign s_tready = en1;

	// input unpack
	logic [COORD_W-1:0] in_x, in_y;
	logic [VALUE_W-1:0] in_v;

	assign in_x = s_tdata[COORD_W-1:0];
	assign in_y = s_tdata[2*COORD_W-1:COORD_W];
	assign in_v = s_tdata[S_PAYLOAD_W-1:2*COORD_W];

	// stage 1 logic: tile position, tile counts, drop decision
	logic [DIM_W-1:0]      w_clamp, h_clamp;
	logic [TILE_POS_W-1:0] tcol, trow;
	logic [TILE_CNT_W-1:0] ntx, nty;
	logic [INNER_W-1:0]    inner;
	logic                  bad_fmt, odd_col, drop;

	assign w_clamp = (width_q > MaxDim) ? MaxDim : width_q;
	assign h_clamp = (height_q > MaxDim) ? MaxDim : height_q;

	always_comb begin
		tcol    = '0;
		trow    = '0;
		ntx     = '0;
		nty     = '0;
		inner   = '0;
		bad_fmt = 1'b0;
		odd_col = 1'b0;
		unique case (fmt_q)
			FMT_RGBA8: begin
				tcol  = in_x[COORD_W-1:2];
				trow  = in_y[COORD_W-1:2];
				ntx   = w_clamp[DIM_W-1:2];
				nty   = h_clamp[DIM_W-1:2];
				inner = {in_y[1:0], in_x[1:0], 1'b0};
			end
			FMT_C8: begin
				tcol  = {1'b0, in_x[COORD_W-1:3]};
				trow  = in_y[COORD_W-1:2];
				ntx   = {1'b0, w_clamp[DIM_W-1:3]};
				nty   = h_clamp[DIM_W-1:2];
				inner = {in_y[1:0], in_x[2:0]};
			end
			FMT_C4: begin
				tcol    = {1'b0, in_x[COORD_W-1:3]};
				trow    = {1'b0, in_y[COORD_W-1:3]};
				ntx     = {1'b0, w_clamp[DIM_W-1:3]};
				nty     = {1'b0, h_clamp[DIM_W-1:3]};
				inner   = {in_y[2:0], in_x[2:1]};
				odd_col = in_x[0];
			end
			default: bad_fmt = 1'b1;
		endcase
	end

	// unknown formats, partial edge tiles and the odd c4 column carry nothing
	assign drop = bad_fmt || odd_col
		|| ({1'b0, tcol} >= ntx) || ({1'b0, trow} >= nty);

	logic [TILE_POS_W-1:0] tcol_s1, trow_s1;
	logic [TILE_CNT_W-1:0] ntx_s1;
	logic [INNER_W-1:0]    inner_s1;
	logic [VALUE_W-1:0]    value_s1;
	logic                  drop_s1, rgba_s1, order_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			tcol_s1  <= tcol;
			trow_s1  <= trow;
			ntx_s1   <= ntx;
			inner_s1 <= inner;
			value_s1 <= in_v;
			drop_s1  <= drop;
			rgba_s1  <= (fmt_q == FMT_RGBA8);
			order_s1 <= order_q;
		end
	end

	// stage 2: tile index = row * tiles_per_row + column, byte pairs
	logic [TILE_IDX_W-1:0] tile_idx;
	logic [PAIR_W-1:0]     p1, p2;
	logic [7:0]            ch_r, ch_g, ch_b, ch_a;

	assign tile_idx = TILE_IDX_W'(trow_s1) * TILE_IDX_W'(ntx_s1) + TILE_IDX_W'(tcol_s1);

	assign ch_r = value_s1[7:0];
	assign ch_g = value_s1[15:8];
	assign ch_b = value_s1[23:16];
	assign ch_a = value_s1[31:24];

	always_comb begin
		if (!rgba_s1) begin
			p1 = {8'd0, ch_r};
			p2 = '0;
		end else if (order_s1) begin
			p1 = {ch_r, ch_g};
			p2 = {ch_b, ch_a};
		end else begin
			p1 = {ch_a, ch_r};
			p2 = {ch_g, ch_b};
		end
	end

	logic [TILE_IDX_W-1:0] tile_idx_s2;
	logic [INNER_W-1:0]    inner_s2;
	logic [PAIR_W-1:0]     p1_s2, p2_s2;
	logic                  drop_s2, rgba_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			tile_idx_s2 <= tile_idx;
			inner_s2    <= inner_s1;
			p1_s2       <= p1;
			p2_s2       <= p2;
			drop_s2     <= drop_s1;
			rgba_s2     <= rgba_s1;
		end
	end

	// stage 3: tile base (64 or 32 bytes per tile) plus in-tile offset
	logic [OFFSET_W-1:0] base, offset;

	assign base   = rgba_s2 ? OFFSET_W'({tile_idx_s2, 6'd0}) : OFFSET_W'({tile_idx_s2, 5'd0});
	assign offset = base + OFFSET_W'(inner_s2);

	logic [OFFSET_W-1:0] offset_s3;
	logic [PAIR_W-1:0]   p1_s3, p2_s3;
	logic                drop_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	// dropped texels report zero offset and zero bytes
	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			offset_s3 <= drop_s2 ? '0 : offset;
			p1_s3     <= drop_s2 ? '0 : p1_s2;
			p2_s3     <= drop_s2 ? '0 : p2_s2;
			drop_s3   <= drop_s2;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = M_TDATA_W'({p2_s3, p1_s3, offset_s3});
	assign m_tuser  = drop_s3;

endmodule : texture_tile_swizzle_address

`default_nettype wire

// File: rtl/core/tts_checker.sv
// port-level checks for the tiled texture address generator, bound to the top
`default_nettype none

module tts_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [tts_pkg::M_TDATA_W-1:0] m_tdata,
	input wire logic                          m_tuser
);

	import tts_pkg::*;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// input backpressure only when every stage is full and the output stalls
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// a dropped texel carries no offset and no bytes
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("dropped word with nonzero data");

	// an accepted word reaches the output register while the output stays ready
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("accepted word missing at output");

endmodule : tts_checker

bind texture_tile_swizzle_address tts_checker u_tts_checker (.*);

`default_nettype wire
